>>> design/tgti_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the terrain grid triangle interpolator.
// No dependencies.
package tgti_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_COL  = 2'd0,
    CMD_LOAD_ROW  = 2'd1,
    CMD_LOAD_ELEV = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  localparam logic [6:0] REG_COLUMN_COUNT = 7'd0;
  localparam logic [6:0] REG_ROW_COUNT    = 7'd1;

  // one request as it travels through the queue
  typedef struct packed {
    cmd_t        command;
    logic [9:0]  column_index;
    logic [9:0]  row_index;
    logic [15:0] load_value;
    logic [15:0] query_x;
    logic [15:0] query_y;
  } req_t;

endpackage

>>> design/tgti_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tgti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tgti_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between front and back.
// Depends on tgti_pkg.
module tgti_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tgti_pkg::req_t din,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tgti_pkg::req_t dout
);

  tgti_pkg::req_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign dout      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= din;
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/tgti_front.sv
`timescale 1ns / 1ps
// Front end: takes commands, flags out-of-range indices and queues requests.
// Depends on tgti_pkg.
module tgti_front #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     command,
  input  logic [5:0]     column_index,
  input  logic [5:0]     row_index,
  input  logic [15:0]    load_value,
  input  logic [15:0]    query_x,
  input  logic [15:0]    query_y,
  input  logic           q_full,
  output logic           push,
  output tgti_pkg::req_t req
);

  logic col_ok;
  logic row_ok;

  assign busy   = q_full;
  assign push   = start && !q_full;
  assign col_ok = (32'(column_index) < MAX_COLUMNS);
  assign row_ok = (32'(row_index) < MAX_ROWS);

  // out-of-range loads become acknowledgements only: the back end writes nothing for them
  always_comb begin
    req.command      = tgti_pkg::cmd_t'(command);
    req.column_index = {4'd0, column_index};
    req.row_index    = {4'd0, row_index};
    req.load_value   = load_value;
    req.query_x      = query_x;
    req.query_y      = query_y;
    // flag ignored loads by pushing an index at the limit
    if (!col_ok) begin
      req.column_index = 10'h3FF;
    end
    if (!row_ok) begin
      req.row_index = 10'h3FF;
    end
  end

endmodule

>>> design/tgti_back.sv
`timescale 1ns / 1ps
// Back end: grid storage, interval search, triangle plane and divider.
// Depends on tgti_pkg and tgti_ram.
module tgti_back #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [6:0]            column_count,
  input  logic [6:0]            row_count,
  input  logic                  q_valid,
  input  tgti_pkg::req_t        req,
  output logic                  pop,
  output logic                  done,
  output logic signed [15:0]    elevation,
  output logic                  inside_res,
  output logic                  was_query
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = CW + RW;

  typedef enum logic [3:0] {
    S_IDLE, S_BOUNDS, S_BCHK, S_CSCAN, S_RSCAN, S_E00, S_E10, S_E01, S_E11,
    S_MUL1, S_MUL2, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [CW-1:0] nx1;
  logic [RW-1:0] ny1;
  logic [CW-1:0] ci;
  logic [RW-1:0] ri;

  logic          col_we, row_we, elv_we;
  logic [CW-1:0] col_ra;
  logic [RW-1:0] row_ra;
  logic [EW-1:0] elv_ra;
  logic [15:0]   col_rd, row_rd, elv_rd;

  logic signed [15:0] qx, qy;
  logic signed [15:0] cprev, rprev;
  logic signed [16:0] dx, dy, px, py;
  logic signed [15:0] z00, z10, z01, z11;
  logic               phase;
  logic               upper;
  logic signed [33:0] d;
  logic signed [33:0] t1, t2;
  logic signed [52:0] num;
  logic [52:0]        rem;
  logic [52:0]        quo;
  logic               neg;
  logic [5:0]         bitn;

  // count clamp to [2, max]
  always_comb begin
    if (column_count < 7'd2) begin
      nx1 = CW'(1);
    end else if (32'(column_count) > MAX_COLUMNS) begin
      nx1 = CW'(MAX_COLUMNS - 1);
    end else begin
      nx1 = CW'(column_count - 7'd1);
    end
    if (row_count < 7'd2) begin
      ny1 = RW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      ny1 = RW'(MAX_ROWS - 1);
    end else begin
      ny1 = RW'(row_count - 7'd1);
    end
  end

  assign pop    = q_valid && (state == S_IDLE);
  assign col_we = pop && (req.command == tgti_pkg::CMD_LOAD_COL)
                  && (req.column_index != 10'h3FF);
  assign row_we = pop && (req.command == tgti_pkg::CMD_LOAD_ROW)
                  && (req.row_index != 10'h3FF);
  assign elv_we = pop && (req.command == tgti_pkg::CMD_LOAD_ELEV)
                  && (req.column_index != 10'h3FF) && (req.row_index != 10'h3FF);

  tgti_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_col (
    .clk(clk), .we(col_we), .waddr(req.column_index[CW-1:0]),
    .wdata(req.load_value), .raddr(col_ra), .rdata(col_rd));
  tgti_ram #(.WIDTH(16), .DEPTH(MAX_ROWS)) u_row (
    .clk(clk), .we(row_we), .waddr(req.row_index[RW-1:0]),
    .wdata(req.load_value), .raddr(row_ra), .rdata(row_rd));
  tgti_ram #(.WIDTH(16), .DEPTH(2 ** EW)) u_elv (
    .clk(clk), .we(elv_we),
    .waddr({req.column_index[CW-1:0], req.row_index[RW-1:0]}),
    .wdata(req.load_value), .raddr(elv_ra), .rdata(elv_rd));

  // read addresses follow the state; the RAMs register the read, so data arrives in the next cycle
  always_comb begin
    col_ra = ci;
    row_ra = ri;
    elv_ra = {ci, ri};
    case (state)
      S_IDLE:   begin col_ra = '0;  row_ra = '0; end
      S_BOUNDS: begin col_ra = nx1; row_ra = ny1; end
      S_BCHK:   col_ra = CW'(1);
      S_CSCAN:  begin col_ra = ci + CW'(1); row_ra = RW'(1); end
      S_RSCAN:  row_ra = ri + RW'(1);
      S_E10:    elv_ra = {ci + CW'(1), ri};
      S_E01:    elv_ra = {ci, ri + RW'(1)};
      S_E11:    elv_ra = {ci + CW'(1), ri + RW'(1)};
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          ci <= '0;
          ri <= '0;
          if (pop) begin
            qx <= req.query_x;
            qy <= req.query_y;
            if (req.command == tgti_pkg::CMD_QUERY) begin
              state <= S_BOUNDS;
            end else begin
              done       <= 1'b1;
              elevation  <= '0;
              inside_res <= 1'b0;
              was_query  <= 1'b0;
            end
          end
        end
        S_BOUNDS: begin
          // first coordinates are on the read ports
          cprev <= col_rd;
          rprev <= row_rd;
          state <= S_BCHK;
        end
        S_BCHK: begin
          if (qx < cprev || qx > $signed(col_rd) || qy < rprev || qy > $signed(row_rd)) begin
            state <= S_OUT;
            inside_res <= 1'b0;
            elevation  <= '0;
          end else begin
            ci    <= CW'(1);
            state <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          // col_rd holds coord[ci] with ci advanced: compare coord[ci-1] pair
          if (ci == '0) begin
            ci <= CW'(1);
          end else if (qx >= cprev && qx <= $signed(col_rd)) begin
            dx <= 17'($signed(col_rd)) - 17'(cprev);
            px <= 17'(qx) - 17'(cprev);
            ci <= ci - CW'(1);
            ri <= RW'(1);
            state <= S_RSCAN;
          end else if (ci == nx1) begin
            state <= S_OUT;
            inside_res <= 1'b0;
            elevation  <= '0;
          end else begin
            cprev <= col_rd;
            ci    <= ci + CW'(1);
          end
        end
        S_RSCAN: begin
          if (qy >= rprev && qy <= $signed(row_rd)) begin
            dy <= 17'($signed(row_rd)) - 17'(rprev);
            py <= 17'(qy) - 17'(rprev);
            ri <= ri - RW'(1);
            state <= S_E00;
          end else if (ri == ny1) begin
            state <= S_OUT;
            inside_res <= 1'b0;
            elevation  <= '0;
          end else begin
            rprev <= row_rd;
            ri    <= ri + RW'(1);
          end
        end
        S_E00: begin
          phase <= 1'b0;
          if (dx <= 0 || dy <= 0) begin
            state <= S_OUT;
            inside_res <= 1'b0;
            elevation  <= '0;
          end else begin
            state <= S_E10;
          end
        end
        S_E10: begin z00 <= elv_rd; state <= S_E01; end
        S_E01: begin z10 <= elv_rd; state <= S_E11; end
        S_E11: begin z01 <= elv_rd; state <= S_MUL1; end
        S_MUL1: begin
          if (!phase) begin
            z11 <= elv_rd;
            d   <= dx * dy;
            t1  <= px * dy;
            t2  <= py * dx;
            phase <= 1'b1;
          end else begin
            upper <= (t1 + t2 > d);
            // qx*dy = d - px*dy, qy*dx = d - py*dx
            if (t1 + t2 > d) begin
              t1 <= d - t2;
              t2 <= d - t1;
            end
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          // terms of the plane: base*d + (a-base)*t1 + (b-base)*t2
          if (!upper) begin
            num <= 53'(z00) * 53'(d) + 53'(17'(z10) - 17'(z00)) * 53'(t1)
                   + 53'(17'(z01) - 17'(z00)) * 53'(t2);
          end else begin
            num <= 53'(z11) * 53'(d) + 53'(17'(z01) - 17'(z11)) * 53'(t2)
                   + 53'(17'(z10) - 17'(z11)) * 53'(t1);
          end
          state <= S_DIV;
          bitn  <= 6'd52;
        end
        S_DIV: begin
          if (bitn == 6'd52 && rem == '0 && quo == quo) begin
            neg <= num[52];
          end
          state <= S_DIV;
          if (bitn == 6'd63) begin
            elevation  <= neg ? -quo[15:0] : quo[15:0];
            inside_res <= 1'b1;
            state      <= S_OUT;
          end else begin
            bitn <= bitn - 6'd1;
          end
        end
        S_OUT: begin
          done      <= 1'b1;
          was_query <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // restoring divider on the magnitude, one bit a cycle
  logic [52:0] mag;
  logic [53:0] trial;
  assign mag   = num[52] ? 53'(-num) : 53'(num);
  assign trial = {rem, mag[bitn]} - {20'd0, d[33:0]};

  always_ff @(posedge clk) begin
    if (state == S_MUL2) begin
      quo <= '0;
      rem <= '0;
    end else if (state == S_DIV && bitn != 6'd63) begin
      if (!trial[53]) begin
        rem <= trial[52:0];
        quo <= {quo[51:0], 1'b1};
      end else begin
        rem <= {rem[51:0], mag[bitn]};
        quo <= {quo[51:0], 1'b0};
      end
    end
  end

endmodule

>>> design/terrain_grid_triangle_interpolator.sv
`timescale 1ns / 1ps
// Top level of the terrain grid triangle interpolator.
// Depends on tgti_pkg, tgti_front, tgti_queue and tgti_back.
//
// Usage: raise start with a command while busy is low; the command is taken
// at that edge. Loads write a column coordinate, a row coordinate or a node
// elevation; queries interpolate on the triangle of the cell that holds the
// point. Every command gives one result, marked by done for one cycle, with
// elevation, inside_res and was_query.
// done for a load rises once the back end takes it from the queue. A query walks
// the column coordinates and then the row coordinates one per cycle through the
// coordinate memory read ports, then fetches four elevations, multiplies and
// runs a bit-serial divider of 53 steps; misses end before the divider.
// A two-entry queue lets new commands be taken while the back end works; busy
// rises when it is full. The user must write counts on the config port only
// while idle; the block does not enforce this. Reset clears control state and
// sets both counts to 2; memories are not cleared. The receiver cannot stall:
// results are never held.
module terrain_grid_triangle_interpolator #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [5:0]         column_index,
  input  logic [5:0]         row_index,
  input  logic signed [15:0] load_value,
  input  logic signed [15:0] query_x,
  input  logic signed [15:0] query_y,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               done,
  output logic signed [15:0] elevation,
  output logic               inside_res,
  output logic               was_query
);

  logic [6:0]     column_count;
  logic [6:0]     row_count;
  logic           q_full, q_valid, push, pop;
  tgti_pkg::req_t fin, fout;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 7'd2;
      row_count    <= 7'd2;
    end else if (cfg_we) begin
      if (cfg_index == tgti_pkg::REG_COLUMN_COUNT) begin
        column_count <= cfg_data;
      end else if (cfg_index == tgti_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end
    end
  end

  tgti_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .start(start), .busy(busy), .command(command), .column_index(column_index),
    .row_index(row_index), .load_value(load_value), .query_x(query_x),
    .query_y(query_y), .q_full(q_full), .push(push), .req(fin));

  tgti_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(fin), .full(q_full),
    .pop(pop), .not_empty(q_valid), .dout(fout));

  tgti_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst(rst), .column_count(column_count), .row_count(row_count),
    .q_valid(q_valid), .req(fout), .pop(pop), .done(done),
    .elevation(elevation), .inside_res(inside_res), .was_query(was_query));

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("push into full queue");
  a_load_ack: assert property (@(posedge clk) disable iff (rst)
    (done && !was_query) |-> (elevation == 16'sd0 && !inside_res))
    else $error("load acknowledgement carries data");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (elevation == 16'sd0)) else $error("miss nonzero");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for terrain_grid_triangle_interpolator.
// Depends on tgti_pkg and the design; predicts every result from its own grid copy.
module testbench;
  import tgti_pkg::*;

  typedef struct {
    logic signed [15:0] elev;
    logic               in_cell;
    logic               is_query;
  } terrain_result_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] command = 0;
  logic [5:0] column_index = 0;
  logic [5:0] row_index = 0;
  logic signed [15:0] load_value = 0;
  logic signed [15:0] query_x = 0;
  logic signed [15:0] query_y = 0;
  logic cfg_we = 0;
  logic [6:0] cfg_index = 0;
  logic [6:0] cfg_data = 0;
  logic done;
  logic signed [15:0] elevation;
  logic inside_res;
  logic was_query;

  terrain_grid_triangle_interpolator DUT (.*);

  // grid copy
  logic signed [15:0] grid_cols [64];
  logic signed [15:0] grid_rows [64];
  logic signed [15:0] grid_elev [64][64];
  bit                 elev_known [64][64];
  logic [6:0]         col_count_reg = 2;
  logic [6:0]         row_count_reg = 2;

  terrain_result_t pending_results [$];
  int mismatches = 0;
  int idle_pct = 38;
  int stall_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_count(logic [6:0] c);
    if (c < 2) return 2;
    if (c > 64) return 64;
    return c;
  endfunction

  // plane value on the triangle holding (x, y); gap flags a corner never loaded
  function automatic void interpolate(input logic signed [15:0] x, input logic signed [15:0] y,
                                      output logic signed [15:0] z, output bit hit,
                                      output bit gap, output int gc, output int gr);
    int nx, ny, ci, ri;
    longint dx, dy, px, py, d, num, z00, z10, z01, z11, qx, qy;
    z = 0; hit = 0; gap = 0; gc = 0; gr = 0;
    nx = clamp_count(col_count_reg);
    ny = clamp_count(row_count_reg);
    if (x < grid_cols[0] || x > grid_cols[nx-1] || y < grid_rows[0] || y > grid_rows[ny-1])
      return;
    ci = -1;
    ri = -1;
    for (int i = 0; i + 1 < nx; i++)
      if (ci < 0 && x >= grid_cols[i] && x <= grid_cols[i+1]) ci = i;
    for (int i = 0; i + 1 < ny; i++)
      if (ri < 0 && y >= grid_rows[i] && y <= grid_rows[i+1]) ri = i;
    if (ci < 0 || ri < 0) return;
    dx = longint'(grid_cols[ci+1]) - grid_cols[ci];
    dy = longint'(grid_rows[ri+1]) - grid_rows[ri];
    if (dx <= 0 || dy <= 0) return;
    for (int k = 0; k < 4; k++)
      if (!gap && !elev_known[ci + k % 2][ri + k / 2]) begin
        gap = 1; gc = ci + k % 2; gr = ri + k / 2;
      end
    if (gap) return;
    px = longint'(x) - grid_cols[ci];
    py = longint'(y) - grid_rows[ri];
    d = dx * dy;
    z00 = grid_elev[ci][ri];
    z10 = grid_elev[ci+1][ri];
    z01 = grid_elev[ci][ri+1];
    z11 = grid_elev[ci+1][ri+1];
    if (px * dy + py * dx <= d) begin
      num = z00 * d + (z10 - z00) * px * dy + (z01 - z00) * py * dx;
    end else begin
      qx = dx - px;
      qy = dy - py;
      num = z11 * d + (z01 - z11) * qx * dy + (z10 - z11) * qy * dx;
    end
    z = 16'(num / d);
    hit = 1;
  endfunction

  task automatic send(cmd_t c, int ci, int ri, int v, int qx, int qy);
    terrain_result_t r;
    bit gap;
    int gc, gr;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= c;
    column_index <= ci;
    row_index <= ri;
    load_value <= v;
    query_x <= qx;
    query_y <= qy;
    do @(posedge clk); while (busy);
    r.elev = 0; r.in_cell = 0; r.is_query = (c == CMD_QUERY);
    case (c)
      CMD_LOAD_COL: grid_cols[ci] = v;
      CMD_LOAD_ROW: grid_rows[ri] = v;
      CMD_LOAD_ELEV: begin
        grid_elev[ci][ri] = v;
        elev_known[ci][ri] = 1;
      end
      default: interpolate(qx, qy, r.elev, r.in_cell, gap, gc, gr);
    endcase
    pending_results.push_back(r);
  endtask

  // load any missing corner first, so no never-written node is read
  task automatic query_at(int qx, int qy);
    logic signed [15:0] z;
    bit hit, gap;
    int gc, gr;
    repeat (4) begin
      interpolate(qx, qy, z, hit, gap, gc, gr);
      if (gap) send(CMD_LOAD_ELEV, gc, gr, $urandom_range(65535), 0, 0);
    end
    send(CMD_QUERY, $urandom_range(63), $urandom_range(63), $urandom_range(65535), qx, qy);
  endtask

  task automatic drain();
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_counts(int cols, int rows);
    drain();
    cfg_we <= 1; cfg_index <= REG_COLUMN_COUNT; cfg_data <= cols;
    @(posedge clk);
    cfg_index <= REG_ROW_COUNT; cfg_data <= rows;
    @(posedge clk);
    cfg_we <= 0;
    col_count_reg = cols;
    row_count_reg = rows;
  endtask

  // ascending coordinates for the first n entries of one axis
  task automatic load_axis(cmd_t c, int n);
    int pos, stride;
    pos = -32768 + $urandom_range(16000);
    stride = (32767 - pos) / n;
    for (int i = 0; i < n; i++) begin
      if (c == CMD_LOAD_COL) send(c, i, $urandom_range(63), pos, 0, 0);
      else send(c, $urandom_range(63), i, pos, 0, 0);
      pos += 1 + $urandom_range(stride - 1);
    end
  endtask

  task automatic test_grid_loads();
    for (int i = 0; i < 64; i++) begin
      send(CMD_LOAD_COL, i, 63 - i, (i == 63) ? 32767 : -32768 + i * 1040, 0, 0);
      send(CMD_LOAD_ROW, 63 - i, i, (i == 63) ? 32767 : -32768 + i * 1040, 0, 0);
    end
    send(CMD_LOAD_ELEV, 0, 0, -32768, 0, 0);
    send(CMD_LOAD_ELEV, 1, 0, 32767, 0, 0);
    send(CMD_LOAD_ELEV, 0, 1, 32767, 0, 0);
    send(CMD_LOAD_ELEV, 1, 1, -32768, 0, 0);
  endtask

  task automatic test_directed_queries();
    int c1, r1;
    c1 = grid_cols[1];
    r1 = grid_rows[1];
    query_at(-32768, -32768);                    // lower-left corner node
    query_at(c1, r1);                            // upper-right corner node
    query_at(-32768, r1);                        // on the diagonal end
    query_at(-32768 + 520, -32768 + 520);        // on the diagonal itself
    query_at(-32768 + 900, -32768 + 800);        // upper triangle
    query_at(-32768 + 100, -32768 + 200);        // lower triangle
    query_at(c1 + 1, -32768);                    // right of grid
    query_at(-32768, r1 + 1);                    // above grid
    write_counts(64, 64);
    query_at(32767, 32767);
    query_at(32767, -32768);
    query_at(0, 0);
    // zero-width cell
    write_counts(3, 3);
    send(CMD_LOAD_COL, 1, 0, grid_cols[0], 0, 0);
    query_at(grid_cols[0], grid_rows[0] + 10);
    send(CMD_LOAD_COL, 1, 0, c1, 0, 0);
    // counts outside the legal range
    write_counts(0, 127);
    query_at(-32768 + 300, 0);
    write_counts(1, 65);
    query_at(-32768 + 300, 32767);
  endtask

  task automatic random_phase(int items);
    int nx, ny, lo_x, hi_x, lo_y, hi_y, sel;
    nx = clamp_count(col_count_reg);
    ny = clamp_count(row_count_reg);
    repeat (items) begin
      sel = $urandom_range(99);
      lo_x = grid_cols[0]; hi_x = grid_cols[nx-1];
      lo_y = grid_rows[0]; hi_y = grid_rows[ny-1];
      if (sel < 4) begin
        send(CMD_LOAD_COL, $urandom_range(63), $urandom_range(63), $urandom_range(65535), 0, 0);
      end else if (sel < 8) begin
        send(CMD_LOAD_ROW, $urandom_range(63), $urandom_range(63), $urandom_range(65535), 0, 0);
      end else if (sel < 25) begin
        send(CMD_LOAD_ELEV, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
             $urandom_range(65535), $urandom_range(65535));
      end else if (sel < 35) begin
        query_at(grid_cols[$urandom_range(nx - 1)], grid_rows[$urandom_range(ny - 1)]);
      end else if (sel < 45 || hi_x < lo_x || hi_y < lo_y) begin
        query_at($urandom_range(65535), $urandom_range(65535));
      end else begin
        query_at(lo_x + $urandom_range(hi_x - lo_x), lo_y + $urandom_range(hi_y - lo_y));
      end
    end
  endtask

  task automatic test_random();
    int shapes [6][2] = '{'{2, 2}, '{64, 64}, '{5, 3}, '{2, 64}, '{64, 2}, '{9, 12}};
    for (int p = 0; p < 6; p++) begin
      write_counts(shapes[p][0], shapes[p][1]);
      load_axis(CMD_LOAD_COL, clamp_count(col_count_reg));
      load_axis(CMD_LOAD_ROW, clamp_count(row_count_reg));
      idle_pct = (p == 2) ? 0 : 38;
      random_phase(p == 1 ? 60 : 110);
    end
    idle_pct = 38;
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    terrain_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: elevation %0d", elevation);
      end else begin
        e = pending_results.pop_front();
        if (elevation !== e.elev || inside_res !== e.in_cell || was_query !== e.is_query) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected elev %0d inside %0b query %0b, got %0d %0b %0b",
                     e.elev, e.in_cell, e.is_query, elevation, inside_res, was_query);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_grid_loads();
    test_directed_queries();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
